// ----- hdl/utf8_checked_line_token_scanner_top_defines.svh -----
// ----------------------------------------------------------------------------
// utf8 checked line token scanner assertion macros
// shared concurrent assertion forms used by the scanner rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_CHECKED_LINE_TOKEN_SCANNER_TOP_DEFINES_SVH
`define UTF8_CHECKED_LINE_TOKEN_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define U8LTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define U8LTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/u8lts_pkg.sv -----
// ----------------------------------------------------------------------------
// u8lts_pkg
// constants and phase codes for the utf8 checked line token scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8lts_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int LINE_WIDTH_DEF  = 32;
    localparam int OUT_WIDTH       = 32;

    localparam logic [0:0] CMD_BYTE = 1'b0;
    localparam logic [0:0] CMD_EOF  = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_BAD_UTF8 = 2'd1;
    localparam status_t ST_NUL      = 2'd2;
    localparam status_t ST_QUOTE    = 2'd3;

    typedef logic [2:0] phase_t;
    localparam phase_t PH_INDENT  = 3'd0;
    localparam phase_t PH_SKIP    = 3'd1;
    localparam phase_t PH_BETWEEN = 3'd2;
    localparam phase_t PH_BARE    = 3'd3;
    localparam phase_t PH_QUOTED  = 3'd4;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_BACKTICK = 8'h60;

    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] TAG_CONT   = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] TAG_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] TAG_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] TAG_LEAD4  = 8'hF0;

    localparam logic [20:0] CP_MIN2    = 21'h000080;
    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;

endpackage

// ----- hdl/utf8_checked_line_token_scanner_top.sv -----
// ----------------------------------------------------------------------------
// utf8_checked_line_token_scanner_top
// validates utf-8 and nul-free content of a byte stream, counts nodes and
// tokens over all lines of a file, and reports a prioritized status at end of file
// ----------------------------------------------------------------------------
//  channel | direction | fields                                   | handshake
//  s_      | in        | command, data_byte                       | s_valid/s_ready
//  m_      | out       | status, node_count, token_count, error_line | m_valid/m_ready
//
//  one transaction per cycle sustained; a byte passes an input register and
//  updates the scan state in the next cycle; an end-of-file transaction passes
//  the input register and its result is then loaded into the result register
//  aresetn (synchronous, active low) clears scan state and the valid flags
//  of both registers; the input side stalls only while an end-of-file
//  transaction waits behind a result that has not been taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_checked_line_token_scanner_top_defines.svh"

module utf8_checked_line_token_scanner_top #(
    parameter int COUNT_WIDTH = u8lts_pkg::COUNT_WIDTH_DEF,
    parameter int LINE_WIDTH  = u8lts_pkg::LINE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [7:0]                          s_data_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output u8lts_pkg::status_t                  m_status,
    output logic [u8lts_pkg::OUT_WIDTH-1:0]     m_node_count,
    output logic [u8lts_pkg::OUT_WIDTH-1:0]     m_token_count,
    output logic [u8lts_pkg::OUT_WIDTH-1:0]     m_error_line
);
    import u8lts_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // scan state
    phase_t                 phase_reg, phase_next;
    logic                   backtick_reg, backtick_next;
    logic [1:0]             pend_reg, pend_next;
    logic [20:0]            cp_reg, cp_next;
    logic [1:0]             len_reg, len_next;
    logic                   u8_err_reg, u8_err_next;
    logic                   nul_reg, nul_next;
    logic                   qerr_reg, qerr_next;
    logic [LINE_WIDTH-1:0]  qline_reg, qline_next;
    logic [LINE_WIDTH-1:0]  line_reg, line_next;
    logic [COUNT_WIDTH-1:0] nodes_reg, nodes_next;
    logic [COUNT_WIDTH-1:0] tokens_reg, tokens_next;

    // result register
    logic                 out_valid_reg;
    status_t              out_status_reg, out_status_next;
    logic [OUT_WIDTH-1:0] out_nodes_reg, out_nodes_next;
    logic [OUT_WIDTH-1:0] out_tokens_reg, out_tokens_next;
    logic [OUT_WIDTH-1:0] out_line_reg, out_line_next;

    logic advance;
    logic eof_fire;
    logic byte_fire;

    assign advance   = in_valid_reg && (!in_cmd_reg || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign eof_fire  = advance && (in_cmd_reg == CMD_EOF);
    assign byte_fire = advance && (in_cmd_reg == CMD_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_byte_reg <= s_data_byte;
        end
    end

    // scan state update
    always_comb begin
        logic [7:0]  b;
        logic        lead;
        logic        sp;
        logic        close_hit;
        logic        tok_start;
        logic [20:0] cp_min;
        logic [63:0] ext;
        logic        u8_final;
        logic        q_final;
        logic [LINE_WIDTH-1:0] ql_final;

        b          = in_byte_reg;
        lead       = 1'b0;
        sp         = (b <= CH_SPACE);
        close_hit  = 1'b0;
        tok_start  = 1'b0;
        cp_min     = CP_MIN4;
        ext        = '0;
        u8_final   = 1'b0;
        q_final    = 1'b0;
        ql_final   = '0;

        phase_next    = phase_reg;
        backtick_next = backtick_reg;
        pend_next     = pend_reg;
        cp_next       = cp_reg;
        len_next      = len_reg;
        u8_err_next   = u8_err_reg;
        nul_next      = nul_reg;
        qerr_next     = qerr_reg;
        qline_next    = qline_reg;
        line_next     = line_reg;
        nodes_next    = nodes_reg;
        tokens_next   = tokens_reg;

        out_status_next = out_status_reg;
        out_nodes_next  = out_nodes_reg;
        out_tokens_next = out_tokens_reg;
        out_line_next   = out_line_reg;

        if (byte_fire) begin
            if (b == CH_NUL) begin
                nul_next = 1'b1;
            end

            // utf-8 decode
            if (pend_reg != 2'd0) begin
                if ((b & MASK_CONT) != TAG_CONT) begin
                    u8_err_next = 1'b1;
                    pend_next   = 2'd0;
                    lead        = 1'b1;
                end else begin
                    cp_next   = {cp_reg[14:0], b[5:0]};
                    pend_next = pend_reg - 2'd1;
                    if (pend_next == 2'd0) begin
                        unique case (len_reg)
                            2'd1:    cp_min = CP_MIN2;
                            2'd2:    cp_min = CP_MIN3;
                            default: cp_min = CP_MIN4;
                        endcase
                        if ((cp_next < cp_min) || (cp_next > CP_MAX) ||
                            ((cp_next >= CP_SUR_LO) && (cp_next <= CP_SUR_HI))) begin
                            u8_err_next = 1'b1;
                        end
                    end
                end
            end else begin
                lead = 1'b1;
            end

            if (lead && b[7]) begin
                priority if ((b & MASK_LEAD2) == TAG_LEAD2) begin
                    len_next  = 2'd1;
                    cp_next   = {16'd0, b[4:0]};
                    pend_next = 2'd1;
                end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
                    len_next  = 2'd2;
                    cp_next   = {17'd0, b[3:0]};
                    pend_next = 2'd2;
                end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
                    len_next  = 2'd3;
                    cp_next   = {18'd0, b[2:0]};
                    pend_next = 2'd3;
                end else begin
                    u8_err_next = 1'b1;
                end
            end

            // line tokenizer
            close_hit = backtick_reg ? (b == CH_BACKTICK) : (b == CH_DQUOTE);
            if (b == CH_LF) begin
                if ((phase_reg == PH_QUOTED) && !qerr_reg) begin
                    qerr_next  = 1'b1;
                    qline_next = line_reg;
                end
                phase_next = PH_INDENT;
                if (!(&line_reg)) begin
                    line_next = line_reg + 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_INDENT, PH_BETWEEN: begin
                        if (!sp) begin
                            if (b == CH_HASH) begin
                                phase_next = PH_SKIP;
                            end else begin
                                tok_start = 1'b1;
                                if ((phase_reg == PH_INDENT) && !(&nodes_reg)) begin
                                    nodes_next = nodes_reg + 1'b1;
                                end
                            end
                        end
                    end
                    PH_BARE: begin
                        if (sp) begin
                            phase_next = PH_BETWEEN;
                        end
                    end
                    PH_QUOTED: begin
                        if (close_hit) begin
                            phase_next = PH_BETWEEN;
                        end
                    end
                    default: begin
                        phase_next = PH_SKIP;
                    end
                endcase
                if (tok_start) begin
                    if (!(&tokens_reg)) begin
                        tokens_next = tokens_reg + 1'b1;
                    end
                    if ((b == CH_DQUOTE) || (b == CH_BACKTICK)) begin
                        backtick_next = (b == CH_BACKTICK);
                        phase_next    = PH_QUOTED;
                    end else begin
                        phase_next = PH_BARE;
                    end
                end
            end
        end

        if (eof_fire) begin
            u8_final = u8_err_reg || (pend_reg != 2'd0);
            q_final  = qerr_reg || (phase_reg == PH_QUOTED);
            ql_final = qerr_reg ? qline_reg : line_reg;

            out_nodes_next  = '0;
            out_tokens_next = '0;
            out_line_next   = '0;
            priority if (u8_final) begin
                out_status_next = ST_BAD_UTF8;
                out_line_next   = OUT_WIDTH'(1);
            end else if (nul_reg) begin
                out_status_next = ST_NUL;
                out_line_next   = OUT_WIDTH'(1);
            end else if (q_final) begin
                out_status_next = ST_QUOTE;
                ext             = 64'(ql_final);
                out_line_next   = (|ext[63:OUT_WIDTH]) ? '1 : ext[OUT_WIDTH-1:0];
            end else begin
                out_status_next = ST_OK;
                ext             = 64'(nodes_reg);
                out_nodes_next  = (|ext[63:OUT_WIDTH]) ? '1 : ext[OUT_WIDTH-1:0];
                ext             = 64'(tokens_reg);
                out_tokens_next = (|ext[63:OUT_WIDTH]) ? '1 : ext[OUT_WIDTH-1:0];
            end

            phase_next    = PH_INDENT;
            backtick_next = 1'b0;
            pend_next     = 2'd0;
            cp_next       = '0;
            len_next      = 2'd0;
            u8_err_next   = 1'b0;
            nul_next      = 1'b0;
            qerr_next     = 1'b0;
            qline_next    = '0;
            line_next     = LINE_WIDTH'(1);
            nodes_next    = '0;
            tokens_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_INDENT;
            backtick_reg <= 1'b0;
            pend_reg     <= 2'd0;
            cp_reg       <= '0;
            len_reg      <= 2'd0;
            u8_err_reg   <= 1'b0;
            nul_reg      <= 1'b0;
            qerr_reg     <= 1'b0;
            qline_reg    <= '0;
            line_reg     <= LINE_WIDTH'(1);
            nodes_reg    <= '0;
            tokens_reg   <= '0;
        end else begin
            phase_reg    <= phase_next;
            backtick_reg <= backtick_next;
            pend_reg     <= pend_next;
            cp_reg       <= cp_next;
            len_reg      <= len_next;
            u8_err_reg   <= u8_err_next;
            nul_reg      <= nul_next;
            qerr_reg     <= qerr_next;
            qline_reg    <= qline_next;
            line_reg     <= line_next;
            nodes_reg    <= nodes_next;
            tokens_reg   <= tokens_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (eof_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_nodes_reg  <= out_nodes_next;
        out_tokens_reg <= out_tokens_next;
        out_line_reg   <= out_line_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_node_count  = out_nodes_reg;
    assign m_token_count = out_tokens_reg;
    assign m_error_line  = out_line_reg;

    `U8LTS_ASSERT_NOW(a_eof_blocked, aclk, aresetn,
        out_valid_reg && !m_ready && in_valid_reg && (in_cmd_reg == CMD_EOF),
        !s_ready, "end of file passed a pending result")
    `U8LTS_ASSERT_NEXT(a_eof_clears, aclk, aresetn, eof_fire,
        (line_reg == LINE_WIDTH'(1)) && (nodes_reg == '0) && (tokens_reg == '0) &&
        !u8_err_reg && !nul_reg && !qerr_reg && (phase_reg == PH_INDENT),
        "scan state not cleared after end of file")
    `U8LTS_ASSERT_NOW(a_ok_no_line, aclk, aresetn,
        out_valid_reg && (out_status_reg == ST_OK), out_line_reg == '0,
        "error line set on ok status")
    `U8LTS_ASSERT_NOW(a_err_no_counts, aclk, aresetn,
        out_valid_reg && (out_status_reg != ST_OK),
        (out_nodes_reg == '0) && (out_tokens_reg == '0),
        "counts reported with error status")
    `U8LTS_ASSERT_NOW(a_pend_le_len, aclk, aresetn, pend_reg != 2'd0,
        pend_reg <= len_reg, "continuation count exceeds sequence length")

endmodule
